### design/utf8_stream_decoder_defines.svh
// Assertion macros used by the decoder checker.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define U8SD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/u8sd_pkg.sv
`default_nettype none

package u8sd_pkg;

   localparam int unsigned CP_W = 21;

   // Byte class boundaries
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD_LIMIT  = 8'hF8;
   localparam logic [1:0] CONT_TAG    = 2'b10;

   // Scalar value limits
   localparam logic [CP_W-1:0] SURR_MIN = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_MAX = 21'h00DFFF;
   localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            error;
   } result_type;

   typedef struct packed {
      logic       emit;
      result_type res;
   } step_type;

endpackage

`default_nettype wire

### design/utf8_stream_decoder.sv
// Path: a request is held in the input register, then its result in the result
//   register; a request that completes no sequence gives no result.
// Throughput: one byte per cycle; the decode stage advances whenever the result
//   register is empty or being drained, so only a stalled result holds the input.
// Reset: synchronous, active high; clears both valid flags and the open sequence.
`default_nettype none

module utf8_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_in,
   input  wire logic        req_end_of_buffer,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [20:0]      rsp_code_point,
   output logic             rsp_error
);

   // Input register: holds one request until the decode stage takes it.
   logic                 in_valid_ff;
   logic                 in_valid_in;
   u8sd_pkg::req_type    in_req_ff;

   // Decode stage handshake
   logic                 out_free;
   logic                 step;
   u8sd_pkg::step_type   step_res;
   u8sd_pkg::result_type out_res;

   // Advance the held request into the decoder when the result register can take
   // whatever it produces; requests that emit nothing still wait for that slot.
   assign step        = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the payload on every accepted request.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff.byte_in       <= req_byte_in;
         in_req_ff.end_of_buffer <= req_end_of_buffer;
      end
   end

   // Decoder: sequence state and per-byte classification.
   u8sd_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (in_req_ff),
      .result (step_res)
   );

   // Result register: drop non-emitting steps, hold results under back-pressure.
   u8sd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step_res.emit),
      .res       (step_res.res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_res   (out_res),
      .free      (out_free)
   );

   assign rsp_code_point = out_res.code_point;
   assign rsp_error      = out_res.error;

endmodule

`default_nettype wire

### design/u8sd_decoder.sv
`default_nettype none

module u8sd_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire u8sd_pkg::req_type  req,
   output u8sd_pkg::step_type      result
);

   logic [u8sd_pkg::CP_W-1:0] partial_ff;
   logic [u8sd_pkg::CP_W-1:0] partial_in;
   logic [1:0]                owed_ff;
   logic [1:0]                owed_in;
   logic [u8sd_pkg::CP_W-1:0] assembled;
   logic [7:0]                b;

   assign b         = req.byte_in;
   assign assembled = {partial_ff[u8sd_pkg::CP_W-7:0], b[5:0]};

   always_comb begin
      partial_in      = partial_ff;
      owed_in         = owed_ff;
      result          = '0;
      if (step) begin
         if (owed_ff == 2'd0) begin
            priority if (b < u8sd_pkg::ASCII_LIMIT) begin
               result.emit           = 1'b1;
               result.res.code_point = {13'd0, b};
            end else if (b < u8sd_pkg::LEAD2_MIN || b >= u8sd_pkg::LEAD_LIMIT) begin
               result.emit      = 1'b1;
               result.res.error = 1'b1;
            end else begin
               priority if (b < u8sd_pkg::LEAD3_MIN) begin
                  partial_in = {16'd0, b[4:0]};
                  owed_in    = 2'd1;
               end else if (b < u8sd_pkg::LEAD4_MIN) begin
                  partial_in = {17'd0, b[3:0]};
                  owed_in    = 2'd2;
               end else begin
                  partial_in = {18'd0, b[2:0]};
                  owed_in    = 2'd3;
               end
               // a lead byte at the end of the buffer is a truncation
               if (req.end_of_buffer) begin
                  partial_in       = '0;
                  owed_in          = 2'd0;
                  result.emit      = 1'b1;
                  result.res.error = 1'b1;
               end
            end
         end else if (b[7:6] != u8sd_pkg::CONT_TAG) begin
            partial_in       = '0;
            owed_in          = 2'd0;
            result.emit      = 1'b1;
            result.res.error = 1'b1;
         end else if (owed_ff == 2'd1) begin
            partial_in  = '0;
            owed_in     = 2'd0;
            result.emit = 1'b1;
            if ((assembled >= u8sd_pkg::SURR_MIN && assembled <= u8sd_pkg::SURR_MAX)
                || assembled > u8sd_pkg::CP_MAX) begin
               result.res.error = 1'b1;
            end else begin
               result.res.code_point = assembled;
            end
         end else begin
            partial_in = assembled;
            owed_in    = owed_ff - 2'd1;
            if (req.end_of_buffer) begin
               partial_in       = '0;
               owed_in          = 2'd0;
               result.emit      = 1'b1;
               result.res.error = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         owed_ff    <= 2'd0;
      end else begin
         partial_ff <= partial_in;
         owed_ff    <= owed_in;
      end
   end

endmodule

`default_nettype wire

### design/u8sd_out_stage.sv
`default_nettype none

module u8sd_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire u8sd_pkg::result_type res,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output u8sd_pkg::result_type      rsp_res,
   output logic                      free
);

   logic                 valid_ff;
   logic                 valid_in;
   u8sd_pkg::result_type res_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

endmodule

`default_nettype wire

### design/u8sd_checker.sv
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

module u8sd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [20:0] rsp_code_point,
   input wire logic        rsp_error
);

   `U8SD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_code_point) && $stable(rsp_error),
      "result changed while stalled")
   `U8SD_ASSERT_NOW(a_err_zero, rsp_valid && rsp_error, rsp_code_point == 21'd0,
      "error result carries a non-zero value")
   `U8SD_ASSERT_NOW(a_cp_range, rsp_valid && !rsp_error, rsp_code_point <= 21'h10FFFF,
      "value above the Unicode range")
   `U8SD_ASSERT_NOW(a_no_surr, rsp_valid && !rsp_error,
      rsp_code_point < 21'h00D800 || rsp_code_point > 21'h00DFFF,
      "surrogate value emitted")
   // the input only backs up behind a stalled result
   `U8SD_ASSERT_NOW(a_req_stall, req_valid && !req_ready, rsp_valid && !rsp_ready,
      "request held off with the result side free")

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_code_point    (rsp_code_point),
   .rsp_error         (rsp_error)
);

`default_nettype wire

### tb/utf8_decode_checker.sv
`timescale 1ns / 1ps

module utf8_decode_checker
   import u8sd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire logic [7:0]      req_byte_in,
   input  wire logic            req_end_of_buffer,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire logic [CP_W-1:0] rsp_code_point,
   input  wire logic            rsp_error,
   output int                   mismatch_count,
   output int                   pending_count,
   output int                   value_count,
   output int                   error_count
);

   // Shadow of the decoder's open sequence
   logic [CP_W-1:0] seq_value;
   logic [1:0]      seq_owed;
   result_type      decoded_q[$];

   function automatic step_type decode_byte(input logic [7:0] b, input logic last);
      step_type        outcome;
      logic [CP_W-1:0] cp;
      outcome = '0;
      if (seq_owed == 2'd0) begin
         if (b < ASCII_LIMIT) begin
            outcome.emit = 1'b1;
            outcome.res.code_point = CP_W'(b);
         end else if (b < LEAD2_MIN || b >= LEAD_LIMIT) begin
            outcome.emit = 1'b1;
            outcome.res.error = 1'b1;
         end else begin
            if (b < LEAD3_MIN) begin
               seq_value = CP_W'(b[4:0]);
               seq_owed  = 2'd1;
            end else if (b < LEAD4_MIN) begin
               seq_value = CP_W'(b[3:0]);
               seq_owed  = 2'd2;
            end else begin
               seq_value = CP_W'(b[2:0]);
               seq_owed  = 2'd3;
            end
            // lead byte that is also the last of the buffer: truncated
            if (last) begin
               outcome.emit = 1'b1;
               outcome.res.error = 1'b1;
            end
         end
      end else if (b[7:6] != CONT_TAG) begin
         // consume the stray byte, drop the sequence
         outcome.emit = 1'b1;
         outcome.res.error = 1'b1;
      end else begin
         seq_value = {seq_value[CP_W-7:0], b[5:0]};
         seq_owed  = seq_owed - 2'd1;
         if (seq_owed == 2'd0) begin
            cp = seq_value;
            outcome.emit = 1'b1;
            if ((cp >= SURR_MIN && cp <= SURR_MAX) || cp > CP_MAX) begin
               outcome.res.error = 1'b1;
            end else begin
               outcome.res.code_point = cp;
            end
         end else if (last) begin
            outcome.emit = 1'b1;
            outcome.res.error = 1'b1;
         end
      end
      // any result closes the sequence
      if (outcome.emit) begin
         seq_value = '0;
         seq_owed  = '0;
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      step_type   outcome;
      result_type want;
      if (reset) begin
         seq_value      = '0;
         seq_owed       = '0;
         decoded_q.delete();
         mismatch_count = 0;
         value_count    = 0;
         error_count    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_error) error_count++;
            else value_count++;
            if (decoded_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result cp=%h err=%b with nothing outstanding",
                           $realtime, rsp_code_point, rsp_error);
               mismatch_count++;
            end else begin
               want = decoded_q.pop_front();
               if (want.code_point !== rsp_code_point || want.error !== rsp_error) begin
                  if (mismatch_count < 10)
                     $display("%0t: mismatch: expected cp=%h err=%b, got cp=%h err=%b",
                              $realtime, want.code_point, want.error,
                              rsp_code_point, rsp_error);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            outcome = decode_byte(req_byte_in, req_end_of_buffer);
            if (outcome.emit) decoded_q.push_back(outcome.res);
         end
      end
      pending_count = decoded_q.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import u8sd_pkg::*;

   localparam int RANDOM_ITEMS   = 1500;
   localparam int WATCHDOG_LIMIT = 3000;  // well over the longest receiver hold-off
   localparam int HOLD_CYCLES    = 400;
   localparam int TAIL_CYCLES    = 8;     // longer than the path through the input and result registers

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [7:0]      req_byte_in;
   logic            req_end_of_buffer;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [CP_W-1:0] rsp_code_point;
   logic            rsp_error;

   int mismatch_count;
   int pending_count;
   int value_count;
   int error_count;
   int bytes_sent;
   int stall_cycles;
   bit steady;     // no idling on either side while set
   bit hold_req;   // ask the receiver for one long hold-off

   utf8_stream_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_point    (rsp_code_point),
      .rsp_error         (rsp_error)
   );

   utf8_decode_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_point    (rsp_code_point),
      .rsp_error         (rsp_error),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .value_count       (value_count),
      .error_count       (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: drop ready at random, except in the steady stretch; on request,
   // hold off for a long stretch so the decoder backs up into its input.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 17);
         end
      end
   end

   // Watchdog: end the run if no request or result moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     stall_cycles, pending_count);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Offer one request; idle first at random, then hold it until accepted.
   // Returns on the falling edge after the handshake.
   task automatic offer_byte(input logic [7:0] b, input logic eob);
      while (!steady && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_byte_in       <= b;
      req_end_of_buffer <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // One random sequence: mostly well-formed with random payload bits,
   // some truncated or corrupted, some plain noise.
   task automatic offer_random_sequence();
      int         kind;
      int         len;
      int         pos;
      logic [7:0] seq [4];
      logic [3:0] eob_at;
      logic [7:0] stray;
      kind   = $urandom_range(99);
      eob_at = '0;
      if (kind < 12) begin
         // noise: any byte, any flag
         len    = $urandom_range(1, 3);
         for (int k = 0; k < 4; k++) seq[k] = 8'($urandom_range(255));
         eob_at = 4'($urandom_range(15)) & 4'($urandom_range(15));
      end else begin
         len = (kind < 24) ? $urandom_range(2, 4) : $urandom_range(1, 4);
         case (len)
            1: seq[0] = 8'($urandom_range(8'h7F));
            2: seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
            3: seq[0] = ($urandom_range(3) == 0) ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF));
            default: seq[0] = ($urandom_range(2) == 0) ? 8'hF4
                                                      : 8'($urandom_range(8'hF0, 8'hF7));
         endcase
         for (int k = 1; k < 4; k++) seq[k] = 8'h80 | 8'($urandom_range(8'h3F));
         if ($urandom_range(99) < 8) eob_at[len-1] = 1'b1;
         if (kind < 24) begin
            if ($urandom_range(1) == 0) begin
               // truncate: end of buffer before the sequence completes
               pos         = $urandom_range(0, len - 2);
               eob_at      = '0;
               eob_at[pos] = 1'b1;
               len         = pos + 1;
            end else begin
               // corrupt one continuation byte
               pos   = $urandom_range(1, len - 1);
               stray = 8'($urandom_range(255));
               if (stray[7:6] == 2'b10) stray[6] = 1'b1;
               seq[pos] = stray;
            end
         end
      end
      for (int k = 0; k < len; k++) offer_byte(seq[k], eob_at[k]);
   endtask

   // Directed requests, {end_of_buffer, byte}
   logic [8:0] directed_q[$] = '{
      9'h000, 9'h07F,                  // ASCII extremes
      9'h0C2, 9'h180,                  // two-byte, end of buffer on the completing byte
      9'h0E0, 9'h080, 9'h080,          // overlong three-byte form, accepted
      9'h0ED, 9'h0A0, 9'h080,          // surrogate D800
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // 10FFFF, top of range
      9'h0F4, 9'h090, 9'h080, 9'h080,  // 110000, out of range
      9'h080, 9'h0C1, 9'h0F8, 9'h0FF,  // bad lead bytes
      9'h1C2,                          // lead byte at end of buffer
      9'h0E2, 9'h041,                  // non-continuation inside a sequence
      9'h0E2, 9'h182                   // truncated mid-sequence
   };

   initial begin
      bit hold_done;
      bit pause_done;
      hold_done         = 1'b0;
      pause_done        = 1'b0;
      steady            = 1'b0;
      hold_req          = 1'b0;
      bytes_sent        = 0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_byte_in       = '0;
      req_end_of_buffer = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_q[i]) offer_byte(directed_q[i][7:0], directed_q[i][8]);

      while (bytes_sent < RANDOM_ITEMS + directed_q.size()) begin
         steady = (bytes_sent >= 300 && bytes_sent < 500);
         // keep offering while the receiver holds off, so the input backs up
         if (!hold_done && bytes_sent >= 700) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
         end
         // pause the sender until every outstanding result has drained
         if (!pause_done && bytes_sent >= 1100) begin
            pause_done = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending_count != 0) @(negedge clock);
         end
         offer_random_sequence();
      end
      req_valid <= 1'b0;

      // drain, then let any result-free request clear the pipeline
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Summary: %0d bytes (%0d directed) decoded; %0d code points, %0d errors checked",
               bytes_sent, directed_q.size(), value_count, error_count);
      $display("Summary: covered truncation, stray bytes, surrogates, range limits, hold-off");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
